FILE: hw/rtl/amgs_pkg.sv
// Shared types and constants for the adjacency matrix graph store.
`timescale 1ns / 1ps
package amgs_pkg;

    localparam int VIDX_W    = 5;
    localparam int WEIGHT_W  = 16;
    localparam int TALLY_W   = 11;
    localparam int MAX_RUN   = 32;
    localparam int RUN_W     = 6;
    localparam logic [TALLY_W-1:0]  TALLY_MAX = 11'd2047;
    localparam logic [WEIGHT_W-1:0] ONE_Q88   = 16'h0100;

    typedef enum logic [2:0] {
        REQ_ADD_VERTEX = 3'd0,
        REQ_REM_VERTEX = 3'd1,
        REQ_INS_EDGE   = 3'd2,
        REQ_REM_EDGE   = 3'd3,
        REQ_QUERY_EDGE = 3'd4,
        REQ_DEGREE     = 3'd5,
        REQ_NEIGHBORS  = 3'd6,
        REQ_COUNT      = 3'd7
    } t_req_type;

    typedef enum logic [0:0] {
        CFG_DIRECTED = 1'b0,
        CFG_WEIGHTED = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        t_req_type                   req_type;
        logic [VIDX_W-1:0]           src_vertex;
        logic [VIDX_W-1:0]           dst_vertex;
        logic signed [WEIGHT_W-1:0]  weight;
    } t_request;

    typedef struct packed {
        logic                        ok;
        logic                        edge_present;
        logic signed [WEIGHT_W-1:0]  edge_weight;
        logic [TALLY_W-1:0]          tally;
        logic [VIDX_W-1:0]           neighbor;
        logic                        neighbor_valid;
        logic                        last;
    } t_result;

endpackage

FILE: hw/rtl/adjacency_matrix_graph_store.sv
// Top level of the adjacency matrix graph store.
//
// Requests arrive on the req channel (i_req_valid / o_req_stall), results
// leave on the res channel (o_res_valid / i_res_stall); a word moves when
// valid is high and stall is low. The user must write configuration (directed,
// weighted) through i_cfg_we / i_cfg_idx / i_cfg_data while the block is idle,
// which it does not enforce. One request runs at a time, o_req_stall high meanwhile.
// Work per request, N = vertex count (invalid index or add when full: none):
//   edge insert/remove: cell write, mirrored if undirected; query edge: cell read
//   add vertex: clears the new row and column, one write each
//   degree: reads the row, directed also the column; neighbours: reads the row,
//   held by receiver stalls; count edges: all N*N cells; remove vertex: moves the rest
// Every matrix access goes through the single-port-read RAM, one read or
// write a cycle, and each read's data is looked at in the cycle after it.
// A finished result sits in the output register; the next request is taken
// while it waits, and a stalled receiver only holds up further results.
// Reset clears the vertex count, configuration and output valid; the matrix
// is not cleared since adding a vertex zeroes its row and column.
`timescale 1ns / 1ps
module adjacency_matrix_graph_store #(
    parameter int MAX_VERTICES = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    output logic               o_req_stall,
    input  amgs_pkg::t_request i_req,
    output logic               o_res_valid,
    input  logic               i_res_stall,
    output amgs_pkg::t_result  o_res,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic               i_cfg_data
);
    import amgs_pkg::*;

    localparam int VW = $clog2(MAX_VERTICES);
    localparam int NW = $clog2(MAX_VERTICES + 1);
    localparam int AW = 2 * VW;
    localparam int CW = $clog2(MAX_VERTICES * MAX_VERTICES + 1);
    localparam int KW = (NW > VIDX_W) ? NW : VIDX_W;
    localparam int TW = (CW > TALLY_W) ? CW : TALLY_W;

    typedef enum logic [7:0] {
        ST_IDLE    = 8'b0000_0001,
        ST_CLR     = 8'b0000_0010,
        ST_MOVE_RD = 8'b0000_0100,
        ST_MOVE_WR = 8'b0000_1000,
        ST_MIRROR  = 8'b0001_0000,
        ST_RD      = 8'b0010_0000,
        ST_EVAL    = 8'b0100_0000,
        ST_EMIT    = 8'b1000_0000
    } t_state;

    t_state            r_state, n_state;
    t_req_type         r_op, n_op;
    logic [NW-1:0]     r_n, n_n;
    logic              r_dir, r_wtd;
    logic [VW-1:0]     r_i, n_i, r_j, n_j, r_s, n_s, r_d, n_d;
    logic              r_phase, n_phase, r_col, n_col;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [RUN_W-1:0]  r_found, n_found;
    logic              r_pend_v, n_pend_v;
    logic [VW-1:0]     r_pend, n_pend;
    logic [WEIGHT_W-1:0] r_wval, n_wval;
    t_result           r_res, n_res;
    logic              r_out_valid;
    t_result           r_out;

    logic              out_load;
    t_result           out_data;
    logic              out_free;

    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [WEIGHT_W-1:0] ram_wdata, ram_rdata;

    logic              s_ok, d_ok, nz, j_last, i_last;
    logic [VW-1:0]     src_v, dst_v, n_v;
    logic [CW-1:0]     cnt_nx;
    logic [RUN_W-1:0]  found_nx;
    logic [WEIGHT_W-1:0] edge_val;

    amgs_ram #(
        .WIDTH (WEIGHT_W),
        .DEPTH (2 ** AW)
    ) u_matrix (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    function automatic logic [TALLY_W-1:0] sat(input logic [CW-1:0] v);
        logic [TW-1:0] x;
        x = TW'(v);
        return (x > TW'(TALLY_MAX)) ? TALLY_MAX : x[TALLY_W-1:0];
    endfunction

    function automatic t_result base_res(input logic ok);
        t_result r;
        r = '0;
        r.ok = ok;
        r.last = 1'b1;
        return r;
    endfunction

    assign s_ok   = KW'(i_req.src_vertex) < KW'(r_n);
    assign d_ok   = KW'(i_req.dst_vertex) < KW'(r_n);
    assign src_v  = VW'(i_req.src_vertex);
    assign dst_v  = VW'(i_req.dst_vertex);
    assign n_v    = r_n[VW-1:0];
    assign nz     = |ram_rdata;
    assign j_last = (NW'(r_j) + NW'(1)) == r_n;
    assign i_last = (NW'(r_i) + NW'(1)) == r_n;
    assign cnt_nx = r_cnt + CW'(nz);
    assign found_nx = r_found + RUN_W'(nz);
    assign out_free = !r_out_valid || !i_res_stall;
    assign edge_val = (i_req.req_type == REQ_REM_EDGE) ? '0 :
                      (r_wtd ? i_req.weight : ONE_Q88);

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_n      = r_n;
        n_i      = r_i;
        n_j      = r_j;
        n_s      = r_s;
        n_d      = r_d;
        n_phase  = r_phase;
        n_col    = r_col;
        n_cnt    = r_cnt;
        n_found  = r_found;
        n_pend_v = r_pend_v;
        n_pend   = r_pend;
        n_wval   = r_wval;
        n_res    = r_res;
        out_load = 1'b0;
        out_data = r_res;
        ram_we   = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_re   = 1'b0;
        ram_raddr = {r_i, r_j};

        unique case (r_state)
            ST_IDLE: begin
                if (i_req_valid) begin
                    n_op    = i_req.req_type;
                    n_s     = src_v;
                    n_d     = dst_v;
                    n_cnt   = '0;
                    n_found = '0;
                    n_pend_v = 1'b0;
                    n_col   = 1'b0;
                    n_phase = 1'b0;
                    n_res   = base_res(1'b0);
                    n_state = ST_EMIT;
                    unique case (i_req.req_type)
                        REQ_ADD_VERTEX: begin
                            if (r_n >= NW'(MAX_VERTICES)) begin
                                n_res.tally = TALLY_W'(r_n);
                            end else begin
                                n_i = '0;
                                n_state = ST_CLR;
                            end
                        end
                        REQ_REM_VERTEX: begin
                            if (s_ok) begin
                                n_i = '0;
                                n_j = '0;
                                n_state = ST_MOVE_RD;
                            end
                        end
                        REQ_INS_EDGE, REQ_REM_EDGE: begin
                            if (s_ok && d_ok) begin
                                ram_we    = 1'b1;
                                ram_waddr = {src_v, dst_v};
                                ram_wdata = edge_val;
                                n_wval    = edge_val;
                                n_res     = base_res(1'b1);
                                if (!r_dir) begin
                                    n_state = ST_MIRROR;
                                end
                            end
                        end
                        REQ_QUERY_EDGE: begin
                            if (s_ok && d_ok) begin
                                n_i = src_v;
                                n_j = dst_v;
                                n_state = ST_RD;
                            end
                        end
                        REQ_DEGREE, REQ_NEIGHBORS: begin
                            if (s_ok) begin
                                n_i = src_v;
                                n_j = '0;
                                n_state = ST_RD;
                            end
                        end
                        REQ_COUNT: begin
                            n_res = base_res(1'b1);
                            if (r_n != '0) begin
                                n_i = '0;
                                n_j = '0;
                                n_state = ST_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_CLR: begin
                ram_we = 1'b1;
                ram_waddr = r_phase ? {r_i, n_v} : {n_v, r_i};
                n_phase = !r_phase;
                if (r_phase) begin
                    if (r_i == n_v) begin
                        n_n = r_n + NW'(1);
                        n_res = base_res(1'b1);
                        n_res.tally = TALLY_W'(r_n + NW'(1));
                        n_state = ST_EMIT;
                    end else begin
                        n_i = r_i + VW'(1);
                    end
                end
            end
            ST_MOVE_RD, ST_MOVE_WR: begin
                if (r_state == ST_MOVE_RD && r_i != r_s && r_j != r_s) begin
                    ram_re = 1'b1;
                    n_state = ST_MOVE_WR;
                end else begin
                    if (r_state == ST_MOVE_WR) begin
                        ram_we = 1'b1;
                        ram_waddr = {(r_i > r_s) ? r_i - VW'(1) : r_i,
                                     (r_j > r_s) ? r_j - VW'(1) : r_j};
                        ram_wdata = ram_rdata;
                    end
                    n_state = ST_MOVE_RD;
                    if (j_last) begin
                        n_j = '0;
                        if (i_last) begin
                            n_n = r_n - NW'(1);
                            n_res = base_res(1'b1);
                            n_state = ST_EMIT;
                        end else begin
                            n_i = r_i + VW'(1);
                        end
                    end else begin
                        n_j = r_j + VW'(1);
                    end
                end
            end
            ST_MIRROR: begin
                ram_we = 1'b1;
                ram_waddr = {r_d, r_s};
                ram_wdata = r_wval;
                n_state = ST_EMIT;
            end
            ST_RD: begin
                ram_re = 1'b1;
                n_state = ST_EVAL;
            end
            ST_EVAL: begin
                n_state = ST_RD;
                unique case (r_op)
                    REQ_QUERY_EDGE: begin
                        n_res = base_res(1'b1);
                        n_res.edge_present = nz;
                        n_res.edge_weight = ram_rdata;
                        n_state = ST_EMIT;
                    end
                    REQ_DEGREE: begin
                        n_cnt = cnt_nx;
                        if (!r_col) begin
                            if (!j_last) begin
                                n_j = r_j + VW'(1);
                            end else if (r_dir) begin
                                n_col = 1'b1;
                                n_i = '0;
                                n_j = r_s;
                            end else begin
                                n_state = ST_EMIT;
                            end
                        end else if (!i_last) begin
                            n_i = r_i + VW'(1);
                        end else begin
                            n_state = ST_EMIT;
                        end
                        n_res = base_res(1'b1);
                        n_res.tally = sat(cnt_nx);
                    end
                    REQ_NEIGHBORS: begin
                        if (nz && r_pend_v && !out_free) begin
                            n_state = ST_EVAL;
                        end else begin
                            if (nz) begin
                                if (r_pend_v) begin
                                    out_load = 1'b1;
                                    out_data = '0;
                                    out_data.ok = 1'b1;
                                    out_data.neighbor = VIDX_W'(r_pend);
                                    out_data.neighbor_valid = 1'b1;
                                end
                                n_pend_v = 1'b1;
                                n_pend = r_j;
                                n_found = found_nx;
                            end
                            n_res = base_res(1'b1);
                            if (nz || r_pend_v) begin
                                n_res.neighbor = VIDX_W'(nz ? r_j : r_pend);
                                n_res.neighbor_valid = 1'b1;
                            end
                            if (j_last || found_nx == RUN_W'(MAX_RUN)) begin
                                n_state = ST_EMIT;
                            end else begin
                                n_j = r_j + VW'(1);
                            end
                        end
                    end
                    default: begin
                        n_cnt = cnt_nx;
                        n_res = base_res(1'b1);
                        n_res.tally = sat(r_dir ? cnt_nx : (cnt_nx >> 1));
                        if (j_last) begin
                            n_j = '0;
                            if (i_last) begin
                                n_state = ST_EMIT;
                            end else begin
                                n_i = r_i + VW'(1);
                            end
                        end else begin
                            n_j = r_j + VW'(1);
                        end
                    end
                endcase
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    out_data = r_res;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_n         <= '0;
            r_dir       <= 1'b0;
            r_wtd       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_n     <= n_n;
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_DIRECTED: r_dir <= i_cfg_data;
                    CFG_WEIGHTED: r_wtd <= i_cfg_data;
                    default: ;
                endcase
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_res_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_i      <= n_i;
        r_j      <= n_j;
        r_s      <= n_s;
        r_d      <= n_d;
        r_phase  <= n_phase;
        r_col    <= n_col;
        r_cnt    <= n_cnt;
        r_found  <= n_found;
        r_pend_v <= n_pend_v;
        r_pend   <= n_pend;
        r_wval   <= n_wval;
        r_res    <= n_res;
        if (out_load) begin
            r_out <= out_data;
        end
    end

    assign o_req_stall = (r_state != ST_IDLE);
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;
endmodule

FILE: hw/rtl/amgs_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module amgs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: hw/rtl/amgs_checker.sv
// Port-level checks for the adjacency matrix graph store, bound to the top.
`timescale 1ns / 1ps
module amgs_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_req_valid,
    input logic              o_req_stall,
    input logic              o_res_valid,
    input logic              i_res_stall,
    input amgs_pkg::t_result o_res
);
    import amgs_pkg::*;

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res_valid)
        else $error("result valid after reset");

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && i_res_stall |=> o_res_valid && $stable(o_res))
        else $error("stalled result word changed");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && !o_req_stall |=> o_req_stall)
        else $error("request taken while another is in work");

    a_end_of_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !o_res.neighbor_valid |-> o_res.last)
        else $error("non-neighbor word without last");

    a_present_weight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.edge_present |-> o_res.edge_weight != 0)
        else $error("edge present with zero weight");
endmodule

bind adjacency_matrix_graph_store amgs_checker u_amgs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req_valid),
    .o_req_stall (o_req_stall),
    .o_res_valid (o_res_valid),
    .i_res_stall (i_res_stall),
    .o_res       (o_res)
);
